@@ src/cbez_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the cubic bezier point evaluator
// no dependencies

package cbez_pkg;

	// configuration register file
	localparam int CFG_INDEX_BITS = 3;
	localparam int NUM_CTRL = 4;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CTRL0_X = 3'd0,
		REG_CTRL0_Y = 3'd1,
		REG_CTRL1_X = 3'd2,
		REG_CTRL1_Y = 3'd3,
		REG_CTRL2_X = 3'd4,
		REG_CTRL2_Y = 3'd5,
		REG_CTRL3_X = 3'd6,
		REG_CTRL3_Y = 3'd7
	} cfg_reg_t;

	// reset coordinates of the control points
	localparam int CTRL0_X_RST = 100;
	localparam int CTRL0_Y_RST = 100;
	localparam int CTRL1_X_RST = 400;
	localparam int CTRL1_Y_RST = 200;
	localparam int CTRL2_X_RST = 200;
	localparam int CTRL2_Y_RST = 400;
	localparam int CTRL3_X_RST = 500;
	localparam int CTRL3_Y_RST = 500;

endpackage

@@ src/cbez_cfg_regs.sv @@
`timescale 1ns / 1ps
// control point register file, written through a plain write port
// depends on cbez_pkg

module cbez_cfg_regs #(
	parameter int COORD_BITS = 10
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_we,
	input  logic [cbez_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
	input  logic [COORD_BITS-1:0]                       cfg_wdata,
	output logic [cbez_pkg::NUM_CTRL-1:0][COORD_BITS-1:0] ctrl_x,
	output logic [cbez_pkg::NUM_CTRL-1:0][COORD_BITS-1:0] ctrl_y
);

	logic [cbez_pkg::NUM_CTRL-1:0][COORD_BITS-1:0] ctrl_x_q;
	logic [cbez_pkg::NUM_CTRL-1:0][COORD_BITS-1:0] ctrl_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_x_q[0] <= COORD_BITS'(cbez_pkg::CTRL0_X_RST);
			ctrl_y_q[0] <= COORD_BITS'(cbez_pkg::CTRL0_Y_RST);
			ctrl_x_q[1] <= COORD_BITS'(cbez_pkg::CTRL1_X_RST);
			ctrl_y_q[1] <= COORD_BITS'(cbez_pkg::CTRL1_Y_RST);
			ctrl_x_q[2] <= COORD_BITS'(cbez_pkg::CTRL2_X_RST);
			ctrl_y_q[2] <= COORD_BITS'(cbez_pkg::CTRL2_Y_RST);
			ctrl_x_q[3] <= COORD_BITS'(cbez_pkg::CTRL3_X_RST);
			ctrl_y_q[3] <= COORD_BITS'(cbez_pkg::CTRL3_Y_RST);
		end else if (cfg_we) begin
			case (cbez_pkg::cfg_reg_t'(cfg_index))
				cbez_pkg::REG_CTRL0_X: ctrl_x_q[0] <= cfg_wdata;
				cbez_pkg::REG_CTRL0_Y: ctrl_y_q[0] <= cfg_wdata;
				cbez_pkg::REG_CTRL1_X: ctrl_x_q[1] <= cfg_wdata;
				cbez_pkg::REG_CTRL1_Y: ctrl_y_q[1] <= cfg_wdata;
				cbez_pkg::REG_CTRL2_X: ctrl_x_q[2] <= cfg_wdata;
				cbez_pkg::REG_CTRL2_Y: ctrl_y_q[2] <= cfg_wdata;
				cbez_pkg::REG_CTRL3_X: ctrl_x_q[3] <= cfg_wdata;
				cbez_pkg::REG_CTRL3_Y: ctrl_y_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign ctrl_x = ctrl_x_q;
	assign ctrl_y = ctrl_y_q;

endmodule

@@ src/cbez_axis_pipe.sv @@
`timescale 1ns / 1ps
// de casteljau datapath for one axis, four register stages after the t/u stage
// depends on nothing but its parameters; the top level feeds t and u per stage

module cbez_axis_pipe #(
	parameter int COORD_BITS    = 10,
	parameter int T_FRAC_BITS   = 16,
	parameter int OUT_FRAC_BITS = 4
) (
	input  logic                                              clk,
	input  logic [T_FRAC_BITS-1:0]                            t_s1,
	input  logic [T_FRAC_BITS:0]                              u_s1,
	input  logic [T_FRAC_BITS-1:0]                            t_s2,
	input  logic [T_FRAC_BITS:0]                              u_s2,
	input  logic [T_FRAC_BITS-1:0]                            t_s3,
	input  logic [T_FRAC_BITS:0]                              u_s3,
	input  logic [3:0][COORD_BITS-1:0]                        pt,
	output logic [2:0][COORD_BITS+OUT_FRAC_BITS-1:0]          lin,
	output logic [1:0][COORD_BITS+OUT_FRAC_BITS-1:0]          quad,
	output logic [COORD_BITS+OUT_FRAC_BITS-1:0]               curve
);

	localparam int F      = T_FRAC_BITS;
	localparam int LW     = COORD_BITS + F;       // linear point, scale 2^f
	localparam int QW     = COORD_BITS + 2 * F;   // quadratic point, scale 2^2f
	localparam int BW     = 2 * F;                // low-part partial sum
	localparam int OW     = COORD_BITS + OUT_FRAC_BITS;
	localparam int LIN_SH = F - OUT_FRAC_BITS;
	localparam int QSH    = 2 * F - OUT_FRAC_BITS;
	localparam logic [LW:0] LIN_HALF = (LW+1)'((longint'(1) << LIN_SH) >> 1);
	localparam logic [QW:0] Q_HALF   = (QW+1)'((longint'(1) << QSH) >> 1);

	// half-up rounding to the output grid
	function automatic logic [OW-1:0] round_lin(input logic [LW-1:0] v);
		logic [LW:0] s;
		s = {1'b0, v} + LIN_HALF;
		return OW'(s >> LIN_SH);
	endfunction

	function automatic logic [OW-1:0] round_quad(input logic [QW-1:0] v);
		logic [QW:0] s;
		s = {1'b0, v} + Q_HALF;
		return OW'(s >> QSH);
	endfunction

	logic [2:0][LW-1:0] l_next, l_s2;
	logic [1:0][QW-1:0] q_next, q_s3;
	logic [2:0][OW-1:0] lin_s3, lin_s4, lin_s5;
	logic [1:0][OW-1:0] quad_s4, quad_s5;
	logic [QW-1:0]      a_next, a_s4;
	logic [BW-1:0]      b_next, b_s4;
	logic [QW-1:0]      c_sum;
	logic [OW-1:0]      curve_s5;

	// stage 2: linear points
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			l_next[i] = LW'(u_s1) * LW'(pt[i]) + LW'(t_s1) * LW'(pt[i+1]);
		end
	end

	// stage 3: quadratic points
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			q_next[i] = QW'(u_s2) * QW'(l_s2[i]) + QW'(t_s2) * QW'(l_s2[i+1]);
		end
	end

	// stage 4: curve point split into high and low parts of the quadratic points
	always_comb begin
		a_next = QW'(u_s3) * QW'(q_s3[0][QW-1:F]) + QW'(t_s3) * QW'(q_s3[1][QW-1:F]);
		b_next = BW'(u_s3) * BW'(q_s3[0][F-1:0]) + BW'(t_s3) * BW'(q_s3[1][F-1:0]);
	end

	// stage 5: fold in the carry of the low part, then round
	assign c_sum = a_s4 + QW'(b_s4[BW-1:F]);

	always_ff @(posedge clk) begin
		l_s2 <= l_next;
		q_s3 <= q_next;
		for (int i = 0; i < 3; i++) begin
			lin_s3[i] <= round_lin(l_s2[i]);
		end
		a_s4   <= a_next;
		b_s4   <= b_next;
		lin_s4 <= lin_s3;
		for (int i = 0; i < 2; i++) begin
			quad_s4[i] <= round_quad(q_s3[i]);
		end
		curve_s5 <= round_quad(c_sum);
		lin_s5   <= lin_s4;
		quad_s5  <= quad_s4;
	end

	assign lin   = lin_s5;
	assign quad  = quad_s5;
	assign curve = curve_s5;

endmodule

@@ src/cubic_bezier_point_eval_unit.sv @@
`timescale 1ns / 1ps
// top level of the cubic bezier point evaluator
// depends on cbez_pkg, cbez_cfg_regs and cbez_axis_pipe
//
// usage
//   input channel: an item (t_fraction, t times 2^T_FRAC_BITS) is taken at a
//   rising edge where start is high and busy is low. busy stays low: the
//   pipeline takes a new item every cycle.
//   result channel: done is high for exactly one cycle with all twelve point
//   coordinates on the output ports; the receiver has no way to hold it off.
//   results leave in the order the items came in.
//   pipeline: an accepted item passes the t/u stage, linear points, quadratic
//   points, split curve products and carry fold and rounding (five register
//   stages in all) before done goes high. throughput: one
//   item per cycle, since every stage takes a new item each cycle and each
//   holds one row of multipliers or one add and round.
//   configuration: cfg_we with cfg_index and cfg_wdata writes one control
//   point coordinate at once; write only while no item is in flight.
//   reset: arst_n clears the stage valid bits, so nothing in flight survives,
//   and loads the default control points.

module cubic_bezier_point_eval_unit #(
	parameter int COORD_BITS    = 10,
	parameter int T_FRAC_BITS   = 16,
	parameter int OUT_FRAC_BITS = 4
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic [T_FRAC_BITS-1:0]                  t_fraction,
	input  logic                                    cfg_we,
	input  logic [cbez_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [COORD_BITS-1:0]                   cfg_wdata,
	output logic                                    done,
	output logic [COORD_BITS+OUT_FRAC_BITS-1:0]     lin0_x,
	output logic [COORD_BITS+OUT_FRAC_BITS-1:0]     lin0_y,
	output logic [COORD_BITS+OUT_FRAC_BITS-1:0]     lin1_x,
	output logic [COORD_BITS+OUT_FRAC_BITS-1:0]     lin1_y,
	output logic [COORD_BITS+OUT_FRAC_BITS-1:0]     lin2_x,
	output logic [COORD_BITS+OUT_FRAC_BITS-1:0]     lin2_y,
	output logic [COORD_BITS+OUT_FRAC_BITS-1:0]     quad0_x,
	output logic [COORD_BITS+OUT_FRAC_BITS-1:0]     quad0_y,
	output logic [COORD_BITS+OUT_FRAC_BITS-1:0]     quad1_x,
	output logic [COORD_BITS+OUT_FRAC_BITS-1:0]     quad1_y,
	output logic [COORD_BITS+OUT_FRAC_BITS-1:0]     curve_x,
	output logic [COORD_BITS+OUT_FRAC_BITS-1:0]     curve_y
);

	localparam int F  = T_FRAC_BITS;
	localparam int OW = COORD_BITS + OUT_FRAC_BITS;
	localparam logic [F:0] T_ONE = (F+1)'(1) << F;   // 1.0 in t units

	logic [cbez_pkg::NUM_CTRL-1:0][COORD_BITS-1:0] ctrl_x, ctrl_y;

	// valid bits travel alongside the datapath stages
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// t and u = 1 - t, carried to the stages that multiply by them
	logic [F-1:0] t_s1, t_s2, t_s3;
	logic [F:0]   u_s1, u_s2, u_s3;

	logic [2:0][OW-1:0] lin_x, lin_y;
	logic [1:0][OW-1:0] quad_x, quad_y;
	logic               accept;

	// no backpressure anywhere, so the input is always open
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	cbez_cfg_regs #(
		.COORD_BITS (COORD_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.ctrl_x    (ctrl_x),
		.ctrl_y    (ctrl_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// parameter payload, no reset needed
	always_ff @(posedge clk) begin
		t_s1 <= t_fraction;
		u_s1 <= T_ONE - (F+1)'(t_fraction);
		t_s2 <= t_s1;
		u_s2 <= u_s1;
		t_s3 <= t_s2;
		u_s3 <= u_s2;
	end

	cbez_axis_pipe #(
		.COORD_BITS    (COORD_BITS),
		.T_FRAC_BITS   (T_FRAC_BITS),
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_axis_x (
		.clk   (clk),
		.t_s1  (t_s1),
		.u_s1  (u_s1),
		.t_s2  (t_s2),
		.u_s2  (u_s2),
		.t_s3  (t_s3),
		.u_s3  (u_s3),
		.pt    (ctrl_x),
		.lin   (lin_x),
		.quad  (quad_x),
		.curve (curve_x)
	);

	cbez_axis_pipe #(
		.COORD_BITS    (COORD_BITS),
		.T_FRAC_BITS   (T_FRAC_BITS),
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_axis_y (
		.clk   (clk),
		.t_s1  (t_s1),
		.u_s1  (u_s1),
		.t_s2  (t_s2),
		.u_s2  (u_s2),
		.t_s3  (t_s3),
		.u_s3  (u_s3),
		.pt    (ctrl_y),
		.lin   (lin_y),
		.quad  (quad_y),
		.curve (curve_y)
	);

	// result strobe lines up with the last axis stage
	assign done    = valid_s5;
	assign lin0_x  = lin_x[0];
	assign lin0_y  = lin_y[0];
	assign lin1_x  = lin_x[1];
	assign lin1_y  = lin_y[1];
	assign lin2_x  = lin_x[2];
	assign lin2_y  = lin_y[2];
	assign quad0_x = quad_x[0];
	assign quad0_y = quad_y[0];
	assign quad1_x = quad_x[1];
	assign quad1_y = quad_y[1];

	// every result traces back to an accepted item
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result strobe without an accepted item");

	// an item in the first stage always comes out, nothing is dropped
	a_item_completes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ##4 done)
		else $error("item lost in the pipeline");

	// u and t of one item add up to one
	a_u_plus_t: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (({1'b0, u_s1} + (F+2)'(t_s1)) == (F+2)'(T_ONE)))
		else $error("u and t out of step");

endmodule

@@ tb/cbez_point_checker.sv @@
`timescale 1ns / 1ps
// checker for the cubic bezier point evaluator: keeps its own copy of the control
// points, predicts all twelve coordinates of each item and compares them with the results
// depends on cbez_pkg

module cbez_point_checker
	import cbez_pkg::*;
#(
	parameter int COORD_BITS    = 10,
	parameter int T_FRAC_BITS   = 16,
	parameter int OUT_FRAC_BITS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic [T_FRAC_BITS-1:0]              t_fraction,
	input  logic                                cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]           cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_wdata,
	input  logic                                done,
	input  logic [COORD_BITS+OUT_FRAC_BITS-1:0] lin0_x,
	input  logic [COORD_BITS+OUT_FRAC_BITS-1:0] lin0_y,
	input  logic [COORD_BITS+OUT_FRAC_BITS-1:0] lin1_x,
	input  logic [COORD_BITS+OUT_FRAC_BITS-1:0] lin1_y,
	input  logic [COORD_BITS+OUT_FRAC_BITS-1:0] lin2_x,
	input  logic [COORD_BITS+OUT_FRAC_BITS-1:0] lin2_y,
	input  logic [COORD_BITS+OUT_FRAC_BITS-1:0] quad0_x,
	input  logic [COORD_BITS+OUT_FRAC_BITS-1:0] quad0_y,
	input  logic [COORD_BITS+OUT_FRAC_BITS-1:0] quad1_x,
	input  logic [COORD_BITS+OUT_FRAC_BITS-1:0] quad1_y,
	input  logic [COORD_BITS+OUT_FRAC_BITS-1:0] curve_x,
	input  logic [COORD_BITS+OUT_FRAC_BITS-1:0] curve_y,
	output int                                  pending_count,
	output int                                  fail_count
);

	localparam int OUT_BITS = COORD_BITS + OUT_FRAC_BITS;

	typedef logic [OUT_BITS-1:0] coord_t;
	typedef logic [COORD_BITS-1:0] ctrl_t;

	typedef struct {
		coord_t lin0_x, lin0_y, lin1_x, lin1_y, lin2_x, lin2_y;
		coord_t quad0_x, quad0_y, quad1_x, quad1_y, curve_x, curve_y;
	} bezier_points_t;

	ctrl_t ctrl_x [NUM_CTRL];
	ctrl_t ctrl_y [NUM_CTRL];
	bezier_points_t expected_points [$];
	int mismatches = 0;

	assign fail_count = mismatches;

	function automatic coord_t round_half_up(input logic [63:0] v, input int sh);
		if (sh == 0)
			return coord_t'(v);
		return coord_t'((v + (64'd1 << (sh - 1))) >> sh);
	endfunction

	// exact de casteljau on one axis, rounded only at the end
	function automatic void eval_axis(input ctrl_t p0, p1, p2, p3,
			input logic [T_FRAC_BITS-1:0] t,
			output coord_t l0, l1, l2, q0, q1, c);
		logic [63:0] tv, uv, lp0, lp1, lp2, qp0, qp1, cp;
		tv = 64'(t);
		uv = (64'd1 << T_FRAC_BITS) - tv;
		lp0 = uv * p0 + tv * p1;
		lp1 = uv * p1 + tv * p2;
		lp2 = uv * p2 + tv * p3;
		qp0 = uv * lp0 + tv * lp1;
		qp1 = uv * lp1 + tv * lp2;
		cp = uv * qp0 + tv * qp1;
		l0 = round_half_up(lp0, T_FRAC_BITS - OUT_FRAC_BITS);
		l1 = round_half_up(lp1, T_FRAC_BITS - OUT_FRAC_BITS);
		l2 = round_half_up(lp2, T_FRAC_BITS - OUT_FRAC_BITS);
		q0 = round_half_up(qp0, 2 * T_FRAC_BITS - OUT_FRAC_BITS);
		q1 = round_half_up(qp1, 2 * T_FRAC_BITS - OUT_FRAC_BITS);
		c = round_half_up(cp, 3 * T_FRAC_BITS - OUT_FRAC_BITS);
	endfunction

	function automatic bezier_points_t eval_bezier_points(input logic [T_FRAC_BITS-1:0] t);
		bezier_points_t pts;
		eval_axis(ctrl_x[0], ctrl_x[1], ctrl_x[2], ctrl_x[3], t,
			pts.lin0_x, pts.lin1_x, pts.lin2_x, pts.quad0_x, pts.quad1_x, pts.curve_x);
		eval_axis(ctrl_y[0], ctrl_y[1], ctrl_y[2], ctrl_y[3], t,
			pts.lin0_y, pts.lin1_y, pts.lin2_y, pts.quad0_y, pts.quad1_y, pts.curve_y);
		return pts;
	endfunction

	task automatic compare_coord(input string name, input coord_t want, input coord_t got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bezier_points_t want;
		if (!arst_n) begin
			ctrl_x[0] = ctrl_t'(CTRL0_X_RST);
			ctrl_y[0] = ctrl_t'(CTRL0_Y_RST);
			ctrl_x[1] = ctrl_t'(CTRL1_X_RST);
			ctrl_y[1] = ctrl_t'(CTRL1_Y_RST);
			ctrl_x[2] = ctrl_t'(CTRL2_X_RST);
			ctrl_y[2] = ctrl_t'(CTRL2_Y_RST);
			ctrl_x[3] = ctrl_t'(CTRL3_X_RST);
			ctrl_y[3] = ctrl_t'(CTRL3_Y_RST);
			expected_points.delete();
			pending_count <= 0;
		end else begin
			if (done) begin
				if (expected_points.size() == 0) begin
					$display("%0t unexpected result: expected none actual curve (%0d, %0d)",
						$time, curve_x, curve_y);
					mismatches++;
				end else begin
					want = expected_points.pop_front();
					compare_coord("lin0_x", want.lin0_x, lin0_x);
					compare_coord("lin0_y", want.lin0_y, lin0_y);
					compare_coord("lin1_x", want.lin1_x, lin1_x);
					compare_coord("lin1_y", want.lin1_y, lin1_y);
					compare_coord("lin2_x", want.lin2_x, lin2_x);
					compare_coord("lin2_y", want.lin2_y, lin2_y);
					compare_coord("quad0_x", want.quad0_x, quad0_x);
					compare_coord("quad0_y", want.quad0_y, quad0_y);
					compare_coord("quad1_x", want.quad1_x, quad1_x);
					compare_coord("quad1_y", want.quad1_y, quad1_y);
					compare_coord("curve_x", want.curve_x, curve_x);
					compare_coord("curve_y", want.curve_y, curve_y);
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_CTRL0_X: ctrl_x[0] = cfg_wdata;
					REG_CTRL0_Y: ctrl_y[0] = cfg_wdata;
					REG_CTRL1_X: ctrl_x[1] = cfg_wdata;
					REG_CTRL1_Y: ctrl_y[1] = cfg_wdata;
					REG_CTRL2_X: ctrl_x[2] = cfg_wdata;
					REG_CTRL2_Y: ctrl_y[2] = cfg_wdata;
					REG_CTRL3_X: ctrl_x[3] = cfg_wdata;
					REG_CTRL3_Y: ctrl_y[3] = cfg_wdata;
					default: ;
				endcase
			end
			if (start && !busy)
				expected_points.push_back(eval_bezier_points(t_fraction));
			pending_count <= expected_points.size();
		end
	end

endmodule

@@ tb/cubic_bezier_point_eval_unit_tb.sv @@
`timescale 1ns / 1ps
// top of the cubic bezier point evaluator testbench: clock, reset, control point
// loads and curve parameter stimulus; the verdict comes from the checker's count
// depends on cbez_pkg, cbez_point_checker and cubic_bezier_point_eval_unit

module cubic_bezier_point_eval_unit_tb;
	import cbez_pkg::*;

	localparam int COORD_BITS    = 10;
	localparam int T_FRAC_BITS   = 16;
	localparam int OUT_FRAC_BITS = 4;
	localparam int OUT_BITS      = COORD_BITS + OUT_FRAC_BITS;
	localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

	// pipeline depth from accept to done, plus some slack for the final wait
	localparam int PIPE_LATENCY = 6;
	// the slowest legal run stays well under this limit; keep a wide margin
	localparam int CYCLE_LIMIT = 200000;

	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 250;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [T_FRAC_BITS-1:0] t_fraction = '0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [COORD_BITS-1:0] cfg_wdata = '0;
	logic done;
	logic [OUT_BITS-1:0] lin0_x, lin0_y, lin1_x, lin1_y, lin2_x, lin2_y;
	logic [OUT_BITS-1:0] quad0_x, quad0_y, quad1_x, quad1_y, curve_x, curve_y;

	int pending_count;
	int fail_count;
	int cycle_count = 0;

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	cubic_bezier_point_eval_unit #(
		.COORD_BITS(COORD_BITS),
		.T_FRAC_BITS(T_FRAC_BITS),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) i_dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .t_fraction(t_fraction),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.done(done),
		.lin0_x(lin0_x), .lin0_y(lin0_y), .lin1_x(lin1_x), .lin1_y(lin1_y),
		.lin2_x(lin2_x), .lin2_y(lin2_y),
		.quad0_x(quad0_x), .quad0_y(quad0_y), .quad1_x(quad1_x), .quad1_y(quad1_y),
		.curve_x(curve_x), .curve_y(curve_y)
	);

	// watches both channels and the register port, predicts and compares
	cbez_point_checker #(
		.COORD_BITS(COORD_BITS),
		.T_FRAC_BITS(T_FRAC_BITS),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) i_checker (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .t_fraction(t_fraction),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.done(done),
		.lin0_x(lin0_x), .lin0_y(lin0_y), .lin1_x(lin1_x), .lin1_y(lin1_y),
		.lin2_x(lin2_x), .lin2_y(lin2_y),
		.quad0_x(quad0_x), .quad0_y(quad0_y), .quad1_x(quad1_x), .quad1_y(quad1_y),
		.curve_x(curve_x), .curve_y(curve_y),
		.pending_count(pending_count),
		.fail_count(fail_count)
	);

	// watchdog: a hung pipeline or a lost result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// present one item and hold it until the unit takes it
	// start is left high so back-to-back items need no toggle
	task automatic send_item(input logic [T_FRAC_BITS-1:0] t);
		start <= 1'b1;
		t_fraction <= t;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// stop sending and wait until every predicted item has come back,
	// then let the pipeline run empty before touching the registers
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [COORD_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// all eight coordinates, only ever called with the pipeline empty
	task automatic load_curve(input logic [COORD_BITS-1:0] x0, y0, x1, y1, x2, y2, x3, y3);
		write_reg(REG_CTRL0_X, x0);
		write_reg(REG_CTRL0_Y, y0);
		write_reg(REG_CTRL1_X, x1);
		write_reg(REG_CTRL1_Y, y1);
		write_reg(REG_CTRL2_X, x2);
		write_reg(REG_CTRL2_Y, y2);
		write_reg(REG_CTRL3_X, x3);
		write_reg(REG_CTRL3_Y, y3);
		cfg_we <= 1'b0;
	endtask

	// coordinates lean toward the edges of the range now and then
	function automatic logic [COORD_BITS-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return COORD_MAX;
			2: return COORD_BITS'($urandom_range(0, 3));
			default: return COORD_BITS'($urandom_range(0, 1023));
		endcase
	endfunction

	// t mostly uniform, with zero, the top end, tiny steps and
	// values whose low bits sit right on a rounding tie
	function automatic logic [T_FRAC_BITS-1:0] pick_t();
		logic [T_FRAC_BITS-1:0] v;
		v = T_FRAC_BITS'($urandom);
		case ($urandom_range(0, 19))
			0, 1: return '0;
			2: return '1;
			3, 4: return T_FRAC_BITS'($urandom_range(0, 15));
			5, 6: return {v[T_FRAC_BITS-1:12], 12'h800};
			7: return ~T_FRAC_BITS'($urandom_range(0, 15));
			default: return v;
		endcase
	endfunction

	// bursts of random length with random gaps; some bursts are long
	// and some gaps are zero so the unit also sees unbroken streams
	task automatic run_random_items(input int count, input bit drain_midway);
		int sent;
		int burst;
		int gap;
		bit drained;
		sent = 0;
		drained = 1'b0;
		while (sent < count) begin
			burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			for (int k = 0; k < burst && sent < count; k++) begin
				send_item(pick_t());
				sent++;
			end
			// hold the sender off until nothing is in flight
			if (drain_midway && !drained && sent >= count / 2) begin
				drain_results();
				drained = 1'b1;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0)
				pause_sender(gap);
		end
	endtask

	initial begin
		// hold reset, then release it on a rising edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset control points: t zero gives P0, plus the ends and midpoints
		send_item(16'h0000);
		send_item(16'h0001);
		send_item(16'hFFFF);
		send_item(16'h8000);
		send_item(16'h7FFF);
		send_item(16'h4000);
		send_item(16'hC000);
		send_item(16'h0800);
		send_item(16'hAAAA);
		send_item(16'h5555);
		drain_results();

		// every coordinate at its maximum: largest outputs
		load_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_item(16'h0000);
		send_item(16'hFFFF);
		send_item(16'h8000);
		send_item(16'h0001);
		drain_results();

		// every coordinate zero
		load_curve('0, '0, '0, '0, '0, '0, '0, '0);
		send_item(16'hFFFF);
		send_item(16'h0000);
		drain_results();

		// unit steps between points: low bits of t at half a step give ties
		load_curve(10'd0, 10'd1, 10'd1, 10'd0, 10'd0, 10'd1, 10'd1, 10'd0);
		send_item(16'h0800);
		send_item(16'h1800);
		send_item(16'hF800);
		send_item(16'h8000);
		drain_results();

		// random part, a new set of control points for each phase
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				1: load_curve(COORD_MAX, '0, '0, COORD_MAX, COORD_MAX, '0, '0, COORD_MAX);
				2: load_curve('0, COORD_MAX, COORD_MAX, '0, '0, COORD_MAX, COORD_MAX, '0);
				default: load_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
					pick_coord(), pick_coord(), pick_coord(), pick_coord());
			endcase
			run_random_items(ITEMS_PER_PHASE, phase == 3);
			drain_results();
		end

		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
